[hdl/rsbk_pkg.sv]
package rsbk_pkg;

   localparam int KEY_W       = 64;
   localparam int TAG_W       = 16;
   localparam int DEPTH_DEF   = 64;

   // One stored record as it sits in a cell.
   typedef struct packed {
      logic             valid;
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
   } entry_type;

   // Per-cycle command broadcast to every cell.
   typedef struct packed {
      logic ins;    // insert the incoming record in key order
      logic shift;  // move every entry one cell toward the head
   } cell_ctrl_type;

endpackage

[hdl/rsbk_cell.sv]
module rsbk_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  rsbk_pkg::cell_ctrl_type ctrl,
   input  rsbk_pkg::entry_type     new_entry,
   input  rsbk_pkg::entry_type     left_entry,
   input  logic                    left_gt,
   input  rsbk_pkg::entry_type     right_entry,
   output rsbk_pkg::entry_type     entry,
   output logic                    gt
);
   import rsbk_pkg::*;

   logic [KEY_W-1:0] key_ff;
   logic [TAG_W-1:0] tag_ff;
   logic             valid_ff;
   entry_type        entry_in;

   // Empty cells count as greater so they sit at the tail of the order.
   assign gt = !valid_ff || (key_ff > new_entry.key);

   always_comb begin
      entry_in = '{valid: valid_ff, key: key_ff, tag: tag_ff};
      if (ctrl.ins) begin
         if (gt) begin
            entry_in = left_gt ? left_entry : new_entry;
         end
      end else if (ctrl.shift) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= entry_in.valid;
      end
      key_ff <= entry_in.key;
      tag_ff <= entry_in.tag;
   end

   assign entry = '{valid: valid_ff, key: key_ff, tag: tag_ff};

endmodule

[hdl/record_sort_by_key_core.sv]
// Record sorter, insertion-cell chain.
//
// Input channel (req_*): one record per item, a 64-bit key and a 16-bit tag.
// req_last_record closes the set. While loading, one item is taken per cycle;
// each record is inserted at once into its sorted place (after any equal
// keys, so the order is stable). Records past DEPTH are dropped and flagged.
//
// Result channel (rsp_*): after the last item, the stored records stream out
// in ascending key order, one item per cycle while rsp_stall is low. The
// first result is offered the cycle after the last item is accepted.
// rsp_final_result marks the last of the set; rsp_overflow is high on every
// result of a set that lost records. Every result is taken from the single
// head cell that feeds the output.
//
// req_stall is high during the emit phase. A stall on rsp_stall simply holds
// the head cell and the whole chain. Synchronous reset empties every cell,
// clears the count and the overflow flag, and returns to loading.
module record_sort_by_key_core #(
   parameter int DEPTH = rsbk_pkg::DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [rsbk_pkg::KEY_W-1:0] req_record_key,
   input  logic [rsbk_pkg::TAG_W-1:0] req_record_tag,
   input  logic                       req_last_record,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [rsbk_pkg::KEY_W-1:0] rsp_sorted_key,
   output logic [rsbk_pkg::TAG_W-1:0] rsp_sorted_tag,
   output logic                       rsp_final_result,
   output logic                       rsp_overflow
);
   import rsbk_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   localparam logic ST_LOAD = 1'b0;
   localparam logic ST_EMIT = 1'b1;

   logic             state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             dropped_ff, dropped_in;

   logic          req_acc;
   logic          rsp_acc;
   logic          room;
   cell_ctrl_type ctrl;
   entry_type     new_entry;
   entry_type     empty_entry;

   entry_type     cell_entry [DEPTH];
   logic          cell_gt    [DEPTH];

   assign req_stall = (state_ff == ST_EMIT);
   assign req_acc   = req_valid && !req_stall;
   assign rsp_valid = (state_ff == ST_EMIT);
   assign rsp_acc   = rsp_valid && !rsp_stall;
   assign room      = (count_ff < CNT_W'(DEPTH));

   assign new_entry   = '{valid: 1'b1, key: req_record_key, tag: req_record_tag};
   assign empty_entry = '{valid: 1'b0, key: '0, tag: '0};

   assign ctrl.ins   = req_acc && room;
   assign ctrl.shift = rsp_acc;

   // Cell 0 is the head: smallest key, and the source of every result.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_type left_e;
      logic      left_g;
      entry_type right_e;

      if (i == 0) begin : g_head
         assign left_e = empty_entry;
         assign left_g = 1'b0;
      end else begin : g_mid
         assign left_e = cell_entry[i-1];
         assign left_g = cell_gt[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_e = empty_entry;
      end else begin : g_body
         assign right_e = cell_entry[i+1];
      end

      rsbk_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .new_entry  (new_entry),
         .left_entry (left_e),
         .left_gt    (left_g),
         .right_entry(right_e),
         .entry      (cell_entry[i]),
         .gt         (cell_gt[i])
      );
   end

   assign rsp_sorted_key   = cell_entry[0].key;
   assign rsp_sorted_tag   = cell_entry[0].tag;
   assign rsp_final_result = (count_ff == CNT_W'(1));
   assign rsp_overflow     = dropped_ff;

   // Count holds the stored records while loading and the ones left to send
   // while emitting.
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      dropped_in = dropped_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_acc) begin
               if (room) begin
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_last_record) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (rsp_acc) begin
               count_in = count_ff - CNT_W'(1);
               if (count_ff == CNT_W'(1)) begin
                  state_in   = ST_LOAD;
                  dropped_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
      end
   end

endmodule

[tb/tb_record_sort_by_key_core.sv]
module tb_record_sort_by_key_core;
   timeunit 1ns;
   timeprecision 1ps;

   import rsbk_pkg::*;

   localparam int DEPTH = DEPTH_DEF;
   localparam int N_ROWS = 18;
   localparam int HOLD_CYCLES = 300;

   // One sorted record as it leaves the block.
   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
      logic             last_of_set;
      logic             dropped;
   } sorted_rec_type;

   // One row of the directed table. Where typed is set, want is the single
   // result of a one-record set, written out by hand.
   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
      logic             last;
      logic             typed;
      sorted_rec_type   want;
   } load_row_type;

   logic             clock;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [KEY_W-1:0] req_record_key = '0;
   logic [TAG_W-1:0] req_record_tag = '0;
   logic             req_last_record = 1'b0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [KEY_W-1:0] rsp_sorted_key;
   logic [TAG_W-1:0] rsp_sorted_tag;
   logic             rsp_final_result;
   logic             rsp_overflow;

   // Predictor state: records of the set being loaded, in load order.
   logic [KEY_W-1:0] set_keys [$];
   logic [TAG_W-1:0] set_tags [$];
   logic             set_dropped = 1'b0;

   // Sorted records still owed by the block, oldest first.
   sorted_rec_type sorted_due_q [$];

   int fail_count = 0;
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int hold_left = 0;
   bit hold_go = 1'b0;

   load_row_type dir_rows [N_ROWS];

   record_sort_by_key_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_record_key   (req_record_key),
      .req_record_tag   (req_record_tag),
      .req_last_record  (req_last_record),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sorted_key   (rsp_sorted_key),
      .rsp_sorted_tag   (rsp_sorted_tag),
      .rsp_final_result (rsp_final_result),
      .rsp_overflow     (rsp_overflow)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Predictor. Stores the record (or drops it once the store is full); on
   // the last record it sorts the set stably and queues the results. A
   // typed row has its result queued by the caller, but still advances
   // the set state here.
   task automatic take_record(input logic [KEY_W-1:0] key, input logic [TAG_W-1:0] tag,
                              input logic last, input logic typed);
      logic [KEY_W-1:0] k_arr [DEPTH];
      logic [TAG_W-1:0] t_arr [DEPTH];
      logic [KEY_W-1:0] k_hold;
      logic [TAG_W-1:0] t_hold;
      sorted_rec_type   rec;
      int               n;
      int               j;
      if (set_keys.size() < DEPTH) begin
         set_keys.push_back(key);
         set_tags.push_back(tag);
      end else begin
         set_dropped = 1'b1;
      end
      if (!last) return;
      n = set_keys.size();
      for (int i = 0; i < n; i++) begin
         k_arr[i] = set_keys[i];
         t_arr[i] = set_tags[i];
      end
      // insertion sort; strict compare keeps equal keys in load order
      for (int i = 1; i < n; i++) begin
         k_hold = k_arr[i];
         t_hold = t_arr[i];
         j = i;
         while (j > 0 && k_arr[j-1] > k_hold) begin
            k_arr[j] = k_arr[j-1];
            t_arr[j] = t_arr[j-1];
            j--;
         end
         k_arr[j] = k_hold;
         t_arr[j] = t_hold;
      end
      if (!typed) begin
         for (int i = 0; i < n; i++) begin
            rec.key         = k_arr[i];
            rec.tag         = t_arr[i];
            rec.last_of_set = (i == n - 1);
            rec.dropped     = set_dropped;
            sorted_due_q.push_back(rec);
         end
      end
      set_keys.delete();
      set_tags.delete();
      set_dropped = 1'b0;
   endtask

   // Offer one item. Called at a falling edge; returns at the falling edge
   // after the item was taken. Idle gaps drop valid for whole cycles only.
   task automatic send_item(input logic [KEY_W-1:0] key, input logic [TAG_W-1:0] tag,
                            input logic last, input logic typed, input sorted_rec_type want);
      while (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_record_key  <= key;
      req_record_tag  <= tag;
      req_last_record <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      take_record(key, tag, last, typed);
      if (typed) sorted_due_q.push_back(want);
      @(negedge clock);
   endtask

   // Partly small keys (0 to 7) so that equal keys are common; the rest
   // extremes and full-width random values.
   function automatic logic [KEY_W-1:0] pick_key();
      int sel;
      sel = $urandom_range(9);
      case (sel) inside
         0:       return '0;
         1:       return '1;
         [2:4]:   return KEY_W'($urandom_range(7));
         5:       return {32'hFFFF_FFFF, 29'h1FFF_FFFF, 3'($urandom_range(7))};
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   task automatic send_set(input int n);
      for (int i = 0; i < n; i++)
         send_item(pick_key(), TAG_W'($urandom()), (i == n - 1), 1'b0, '0);
   endtask

   // Receiver: random stall, or a long hold-off counted here once asked.
   always @(negedge clock) begin
      if (hold_go) begin
         hold_go = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= (rsp_idle_pct != 0) && ($urandom_range(99) < rsp_idle_pct);
      end
   end

   // Result checker: every taken result against the oldest expectation.
   always @(posedge clock) begin
      sorted_rec_type exp_rec;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (sorted_due_q.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected result: key %h tag %h final %b ovf %b",
                        rsp_sorted_key, rsp_sorted_tag, rsp_final_result, rsp_overflow);
         end else begin
            exp_rec = sorted_due_q.pop_front();
            if (rsp_sorted_key !== exp_rec.key || rsp_sorted_tag !== exp_rec.tag ||
                rsp_final_result !== exp_rec.last_of_set ||
                rsp_overflow !== exp_rec.dropped) begin
               fail_count++;
               if (fail_count <= 10)
                  $display({"mismatch: exp key %h tag %h final %b ovf %b, ",
                            "got key %h tag %h final %b ovf %b"},
                           exp_rec.key, exp_rec.tag, exp_rec.last_of_set, exp_rec.dropped,
                           rsp_sorted_key, rsp_sorted_tag, rsp_final_result, rsp_overflow);
            end
         end
      end
   end

   initial begin
      #3_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      int budget;
      int n;
      // Single-record sets give their result at a glance; longer sets go
      // through the predictor: equal keys, reverse order, all keys equal.
      dir_rows = '{
         '{64'h0, 16'h0000, 1'b1, 1'b1, '{64'h0, 16'h0000, 1'b1, 1'b0}},
         '{'1, 16'hFFFF, 1'b1, 1'b1, '{'1, 16'hFFFF, 1'b1, 1'b0}},
         '{64'h5555_5555_5555_5555, 16'hAAAA, 1'b1, 1'b1,
           '{64'h5555_5555_5555_5555, 16'hAAAA, 1'b1, 1'b0}},
         '{64'hAAAA_AAAA_AAAA_AAAA, 16'h5555, 1'b1, 1'b1,
           '{64'hAAAA_AAAA_AAAA_AAAA, 16'h5555, 1'b1, 1'b0}},
         '{64'h8000_0000_0000_0000, 16'h0001, 1'b1, 1'b1,
           '{64'h8000_0000_0000_0000, 16'h0001, 1'b1, 1'b0}},
         '{64'd7, 16'd1, 1'b0, 1'b0, '0},
         '{64'd3, 16'd2, 1'b0, 1'b0, '0},
         '{64'd7, 16'd3, 1'b0, 1'b0, '0},
         '{64'd0, 16'd4, 1'b0, 1'b0, '0},
         '{'1, 16'd5, 1'b0, 1'b0, '0},
         '{64'd3, 16'd6, 1'b1, 1'b0, '0},
         '{64'd4, 16'd7, 1'b0, 1'b0, '0},
         '{64'd3, 16'd8, 1'b0, 1'b0, '0},
         '{64'd2, 16'd9, 1'b0, 1'b0, '0},
         '{64'd1, 16'd10, 1'b1, 1'b0, '0},
         '{64'd9, 16'd11, 1'b0, 1'b0, '0},
         '{64'd9, 16'd12, 1'b0, 1'b0, '0},
         '{64'd9, 16'd13, 1'b1, 1'b0, '0}
      };

      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int r = 0; r < N_ROWS; r++)
         send_item(dir_rows[r].key, dir_rows[r].tag, dir_rows[r].last,
                   dir_rows[r].typed, dir_rows[r].want);
      req_valid <= 1'b0;

      // Phases: no random idling (with a long hold-off), sender idle, receiver stalling, both light.
      for (int ph = 0; ph < 4; ph++) begin
         @(posedge clock);
         case (ph)
            0: begin req_idle_pct = 0;  rsp_idle_pct = 0;  hold_go = 1'b1; end
            1: begin req_idle_pct = 85; rsp_idle_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_idle_pct = 85; end
            default: begin req_idle_pct = 8; rsp_idle_pct = 8; end
         endcase
         @(negedge clock);
         // Long hold-off: a small set stuck in emit backs up the input
         // while the overflowing set waits, its last record dropped too.
         if (ph == 0) begin
            send_set(3);
            send_set(DEPTH + 3);
         end
         // exactly full: no overflow
         if (ph == 2) send_set(DEPTH);
         budget = 0;
         while (budget < 45) begin
            if ($urandom_range(24) == 0) n = $urandom_range(DEPTH + 4, DEPTH - 1);
            else n = $urandom_range(8, 1);
            send_set(n);
            budget += n;
         end
         req_valid <= 1'b0;
         // sender waits for the block to drain
         while (sorted_due_q.size() != 0) @(negedge clock);
      end

      repeat (30) @(posedge clock);
      if (fail_count == 0 && sorted_due_q.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
